// File: rtl/core/mexp_pkg.sv
// Shared types, constants and the modular add for the modular exponentiation core.
// Used by the channel interfaces, the controller, the datapath and the product units.
// No dependencies.
package mexp_pkg;

  localparam int DATA_W    = 64;
  localparam int WORD_BITS = 64;
  localparam int CFG_IDX_W = 1;

  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_EXPONENT = cfg_idx_t'(0);
  localparam cfg_idx_t REG_MODULUS  = cfg_idx_t'(1);

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic commit;
    logic publish;
  } mexp_cmd_t;

  typedef struct packed {
    logic range_err;
    logic e_zero;
    logic run_done;
  } mexp_sts_t;

  // Computes (x + y) mod n for x, y below n without a carry out of the word.
  function automatic word_t add_mod(word_t x, word_t y, word_t n);
    word_t gap;
    gap = n - y;
    return (gap > x) ? word_t'(x + y) : word_t'(x - gap);
  endfunction

endpackage

// File: rtl/core/mexp_in_if.sv
// Input channel of the modular exponentiation core: valid, ready and the message.
// Depends on mexp_pkg.
interface mexp_in_if;
  import mexp_pkg::*;

  logic  valid;
  logic  ready;
  data_t message;

  modport source (output valid, output message, input ready);
  modport sink   (input valid, input message, output ready);
endinterface

// File: rtl/core/mexp_out_if.sv
// Result channel of the modular exponentiation core: valid, ready, result and error flag.
// Depends on mexp_pkg.
interface mexp_out_if;
  import mexp_pkg::*;

  logic  valid;
  logic  ready;
  data_t result;
  logic  range_error;

  modport source (output valid, output result, output range_error, input ready);
  modport sink   (input valid, input result, input range_error, output ready);
endinterface

// File: rtl/core/modular_exponentiation_64_core.sv
// Top level of the modular exponentiation core: controller plus datapath.
// Depends on mexp_pkg, mexp_in_if, mexp_out_if, mexp_ctrl, mexp_dp.
//
//   Channel   Direction  Handshake      Payload
//   in_chan   sink       valid/ready    message[63:0]
//   out_chan  source     valid/ready    result[63:0], range_error
//   cfg_*     sink       cfg_we only    cfg_index, cfg_data[63:0]
//
// One message at a time. A transaction loads the message, then, for each exponent bit up to
// the highest set one, sets up the double-and-add product units and steps them once for
// each bit of the longer of the two multipliers, then publishes the result.
// A rejected message or a zero exponent goes straight to the publish step.
// Reset is synchronous and clears the configuration registers and the control state.
// A new message is taken while a finished result waits on out_chan.
module modular_exponentiation_64_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  mexp_pkg::cfg_idx_t cfg_index,
  input  mexp_pkg::data_t    cfg_data,
  mexp_in_if.sink            in_chan,
  mexp_out_if.source         out_chan
);
  import mexp_pkg::*;

  mexp_cmd_t cmd;
  mexp_sts_t sts;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mexp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_message      (in_chan.message),
    .cmd             (cmd),
    .sts             (sts),
    .out_result      (out_chan.result),
    .out_range_error (out_chan.range_error)
  );

endmodule

// File: rtl/core/mexp_modmul.sv
// Double-and-add modular multiplier, one multiplier bit per step.
// Depends on mexp_pkg (word_t, add_mod).
module mexp_modmul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            setup,
  input  logic            step,
  input  mexp_pkg::word_t x_in,
  input  mexp_pkg::word_t y_in,
  input  mexp_pkg::word_t n_in,
  output logic            done,
  output mexp_pkg::word_t prod
);
  import mexp_pkg::*;

  word_t mx_r, mx_nxt;
  word_t my_r, my_nxt;
  word_t mac_r, mac_nxt;

  always_comb begin
    mx_nxt  = mx_r;
    my_nxt  = my_r;
    mac_nxt = mac_r;
    if (setup) begin
      mx_nxt  = x_in;
      my_nxt  = y_in;
      mac_nxt = '0;
    end else if (step) begin
      if (my_r[0]) begin
        mac_nxt = add_mod(mac_r, mx_r, n_in);
      end
      mx_nxt = add_mod(mx_r, mx_r, n_in);
      my_nxt = my_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    mx_r  <= mx_nxt;
    my_r  <= my_nxt;
    mac_r <= mac_nxt;
  end

  assign done = (my_r == '0);
  assign prod = mac_r;

  a_doubled_below_modulus: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> (mx_r < n_in))
    else $error("doubling operand not reduced below the modulus");

  a_acc_below_modulus: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> (mac_r < n_in))
    else $error("partial product not reduced below the modulus");

endmodule

// File: rtl/core/mexp_dp.sv
// Datapath: configuration registers, exponent scan, base and accumulator words,
// two product units (multiply and square) and the result register. Depends on mexp_pkg, mexp_modmul.
module mexp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  mexp_pkg::cfg_idx_t  cfg_index,
  input  mexp_pkg::data_t     cfg_data,
  input  mexp_pkg::data_t     in_message,
  input  mexp_pkg::mexp_cmd_t cmd,
  output mexp_pkg::mexp_sts_t sts,
  output mexp_pkg::data_t     out_result,
  output logic                out_range_error
);
  import mexp_pkg::*;

  word_t exp_cfg_r, exp_cfg_nxt;
  word_t mod_cfg_r, mod_cfg_nxt;
  word_t n_r, n_nxt;
  word_t e_r, e_nxt;
  word_t acc_r, acc_nxt;
  word_t base_r, base_nxt;
  logic  err_r, err_nxt;
  word_t res_r, res_nxt;
  logic  rerr_r, rerr_nxt;

  word_t msg_w;
  word_t e_rest;
  logic  acc_ge_n;
  word_t mul_x, mul_y, sqr_y;
  logic  mul_done, sqr_done;
  word_t mul_prod, sqr_prod;

  assign msg_w    = in_message[WORD_BITS-1:0];
  assign e_rest   = e_r >> 1;
  assign acc_ge_n = (acc_r >= n_r);
  assign mul_x    = acc_ge_n ? base_r : acc_r;
  assign mul_y    = !e_r[0] ? '0 : (acc_ge_n ? word_t'(1) : base_r);
  assign sqr_y    = (e_rest != '0) ? base_r : '0;

  mexp_modmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .setup (cmd.setup),
    .step  (cmd.step),
    .x_in  (mul_x),
    .y_in  (mul_y),
    .n_in  (n_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  mexp_modmul u_sqr (
    .clk   (clk),
    .rst_n (rst_n),
    .setup (cmd.setup),
    .step  (cmd.step),
    .x_in  (base_r),
    .y_in  (sqr_y),
    .n_in  (n_r),
    .done  (sqr_done),
    .prod  (sqr_prod)
  );

  always_comb begin
    exp_cfg_nxt = exp_cfg_r;
    mod_cfg_nxt = mod_cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_EXPONENT: exp_cfg_nxt = cfg_data[WORD_BITS-1:0];
        REG_MODULUS:  mod_cfg_nxt = cfg_data[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n_nxt    = n_r;
    e_nxt    = e_r;
    acc_nxt  = acc_r;
    base_nxt = base_r;
    err_nxt  = err_r;
    res_nxt  = res_r;
    rerr_nxt = rerr_r;
    if (cmd.load) begin
      n_nxt    = mod_cfg_r;
      e_nxt    = exp_cfg_r;
      acc_nxt  = word_t'(1);
      base_nxt = msg_w;
      err_nxt  = (msg_w >= mod_cfg_r);
    end
    if (cmd.commit) begin
      if (e_r[0]) begin
        acc_nxt = mul_prod;
      end
      if (e_rest != '0) begin
        base_nxt = sqr_prod;
      end
      e_nxt = e_rest;
    end
    if (cmd.publish) begin
      res_nxt  = err_r ? base_r : acc_r;
      rerr_nxt = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cfg_r <= '0;
      mod_cfg_r <= '0;
    end else begin
      exp_cfg_r <= exp_cfg_nxt;
      mod_cfg_r <= mod_cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    e_r    <= e_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    err_r  <= err_nxt;
    res_r  <= res_nxt;
    rerr_r <= rerr_nxt;
  end

  assign sts.range_err = err_r;
  assign sts.e_zero    = (e_r == '0);
  assign sts.run_done  = mul_done && sqr_done;

  assign out_result      = DATA_W'(res_r);
  assign out_range_error = rerr_r;

endmodule

// File: rtl/core/mexp_ctrl.sv
// Controller state machine: accepts a message, sequences the exponent bits and
// the product runs, and holds the result valid flag. Depends on mexp_pkg.
module mexp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mexp_pkg::mexp_sts_t sts,
  output mexp_pkg::mexp_cmd_t cmd
);
  import mexp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BIT,
    S_RUN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        if (sts.range_err || sts.e_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.setup = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.run_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_BIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.publish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_BIT))
    else $error("accepted transaction did not start the exponent scan");

  a_publish_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || out_ready))
    else $error("result written over a transaction still waiting");

  a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.setup, cmd.step, cmd.commit, cmd.publish}))
    else $error("more than one datapath command at once");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for modular_exponentiation_64_core: message^exponent mod modulus.
// Depends on mexp_pkg, mexp_in_if, mexp_out_if and the core; predicts with 128-bit products.
module tb;
  import mexp_pkg::*;

  typedef struct packed {
    data_t result;
    logic  range_error;
  } modexp_result_t;

  localparam data_t       ALL_ONES    = '1;
  localparam data_t       TOP_PRIME   = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned HOLD_CYCLES = 15_000;
  localparam int unsigned TAIL_CYCLES = 4_400;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  data_t    cfg_data;

  mexp_in_if  in_chan ();
  mexp_out_if out_chan ();

  modular_exponentiation_64_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  data_t          pending_messages[$];
  modexp_result_t expected_results[$];
  data_t          exponent_shadow;
  data_t          modulus_shadow;
  logic           steady;
  int unsigned    mismatches;
  int unsigned    results_checked;
  int unsigned    in_gap;
  int unsigned    out_stall;
  int unsigned    hold_left;
  logic           hold_done;
  int unsigned    cycle_count;

  function automatic data_t mul_mod_wide(data_t a, data_t b, data_t n);
    logic [127:0] product;
    product = {64'd0, a} * {64'd0, b};
    return data_t'(product % {64'd0, n});
  endfunction

  function automatic modexp_result_t modexp_predict(data_t message);
    modexp_result_t res;
    data_t          acc;
    data_t          base;
    res.range_error = (message >= modulus_shadow);
    if (res.range_error) begin
      res.result = message;
    end else if (exponent_shadow == '0) begin
      res.result = data_t'(1);
    end else begin
      acc  = data_t'(1);
      base = message;
      for (int i = 0; i < WORD_BITS; i++) begin
        if (exponent_shadow[i]) acc = mul_mod_wide(acc, base, modulus_shadow);
        base = mul_mod_wide(base, base, modulus_shadow);
      end
      res.result = acc;
    end
    return res;
  endfunction

  function automatic data_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic data_t rand_exponent();
    case ($urandom_range(0, 3))
      0: return rand_word();
      1: return rand_word() | {1'b1, 63'd0};
      2: return data_t'($urandom_range(1, 65535));
      default: return data_t'($urandom_range(2, 20));
    endcase
  endfunction

  function automatic data_t rand_modulus();
    case ($urandom_range(0, 3))
      0: return rand_word() | {1'b1, 63'd0};
      1: return rand_word();
      2: return (rand_word() >> $urandom_range(8, 60)) | data_t'(2);
      default: return ALL_ONES - data_t'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic data_t rand_message(data_t n);
    data_t r;
    r = rand_word();
    case ($urandom_range(0, 9))
      0: return n;
      1: return r | n;
      2: return (n == '0) ? r : n - data_t'(1);
      default: return (n == '0) ? r : r % n;
    endcase
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (pending_messages.size() != 0 || in_chan.valid || expected_results.size() != 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, data_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_EXPONENT) exponent_shadow = value;
    else modulus_shadow = value;
  endtask

  task automatic set_keys(data_t e, data_t n);
    drain();
    write_reg(REG_EXPONENT, e);
    write_reg(REG_MODULUS, n);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sender: a transaction is taken at each edge with valid and ready both high.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        expected_results.push_back(modexp_predict(in_chan.message));
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending_messages.size() == 0) begin
          in_chan.valid <= 1'b0;
        end else if (!steady && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 7);
          in_chan.valid <= 1'b0;
        end else begin
          in_chan.valid   <= 1'b1;
          in_chan.message <= pending_messages.pop_front();
        end
      end
    end
  end

  // Receiver: checks each result transaction and applies back-pressure, once for a long hold.
  always @(posedge clk) begin : monitor
    modexp_result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      out_stall = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: result=%h range_error=%b",
                   $time, out_chan.result, out_chan.range_error);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_chan.result !== want.result) begin
            $display("%0t: result mismatch: expected %h, actual %h",
                     $time, want.result, out_chan.result);
            mismatches++;
          end
          if (out_chan.range_error !== want.range_error) begin
            $display("%0t: range_error mismatch: expected %b, actual %b",
                     $time, want.range_error, out_chan.range_error);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (!hold_done && results_checked >= 25) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_chan.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_chan.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(0, 7);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin
    data_t n;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_EXPONENT;
    cfg_data        = '0;
    in_chan.valid   = 1'b0;
    in_chan.message = '0;
    out_chan.ready  = 1'b0;
    exponent_shadow = '0;
    modulus_shadow  = '0;
    steady          = 1'b0;
    mismatches      = 0;
    results_checked = 0;
    cycle_count     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers still at reset: a zero modulus rejects every message.
    pending_messages.push_back('0);
    pending_messages.push_back(ALL_ONES);
    pending_messages.push_back(data_t'(1));

    set_keys('0, ALL_ONES);
    pending_messages.push_back('0);
    pending_messages.push_back(ALL_ONES - data_t'(1));
    pending_messages.push_back(ALL_ONES);

    set_keys(ALL_ONES, ALL_ONES);
    pending_messages.push_back('0);
    pending_messages.push_back(data_t'(1));
    pending_messages.push_back(data_t'(2));
    pending_messages.push_back(ALL_ONES - data_t'(1));
    pending_messages.push_back(ALL_ONES);

    set_keys(data_t'(1), data_t'(1));
    pending_messages.push_back('0);
    pending_messages.push_back(data_t'(1));

    set_keys('0, data_t'(1));
    pending_messages.push_back('0);

    set_keys(data_t'(65537), TOP_PRIME);
    pending_messages.push_back(TOP_PRIME - data_t'(1));
    pending_messages.push_back(TOP_PRIME);
    pending_messages.push_back(TOP_PRIME + data_t'(1));
    pending_messages.push_back(64'h1234_5678_9ABC_DEF0);

    for (int p = 0; p < 6; p++) begin
      n = rand_modulus();
      set_keys(rand_exponent(), n);
      steady = (p == 5);
      for (int k = 0; k < 20; k++) pending_messages.push_back(rand_message(n));
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
